// File: design/comment_and_space_stripper_macros.svh
// Assertion macros shared by the comment and space stripper modules.
`ifndef COMMENT_AND_SPACE_STRIPPER_MACROS_SVH
`define COMMENT_AND_SPACE_STRIPPER_MACROS_SVH

// Property checked on every clock edge once reset is released.
`define CSS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication with the consequent checked in the next cycle.
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/csstrip_pkg.sv
// Shared types and constants for the comment and space stripper.
package csstrip_pkg;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_LSQ    = 8'h5B;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_RSQ    = 8'h5D;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Result queue sizing
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = OQ_PTR_W + 1;

	// Scanner flags carried from byte to byte
	typedef struct packed {
		logic [7:0] prev_kept;
		logic       in_quote;
		logic       in_line_comment;
		logic       in_block_comment;
		logic       drop_next;
	} strip_state_t;

	localparam strip_state_t STATE_RESET = '{
		prev_kept:        CH_SPACE,
		in_quote:         1'b0,
		in_line_comment:  1'b0,
		in_block_comment: 1'b0,
		drop_next:        1'b0
	};

	// One result item
	typedef struct packed {
		logic [7:0] char_out;
		logic       has_char;
		logic       end_of_text;
		logic       last_of_run;
	} strip_res_t;

endpackage

// File: design/csstrip_judge.sv
// Keep/drop decision for one byte given its follower, with flag update.
module csstrip_judge (
	input  csstrip_pkg::strip_state_t cur_state,
	input  logic [7:0]                b,
	input  logic [7:0]                nx,
	output csstrip_pkg::strip_state_t next_state,
	output logic                      keep,
	output logic [7:0]                kept
);
	import csstrip_pkg::*;

	logic commented;
	logic b_blank;
	logic prev_open;

	assign commented = cur_state.in_line_comment | cur_state.in_block_comment;
	assign b_blank   = (b == CH_SPACE) || (b == CH_NL);
	assign prev_open = (cur_state.prev_kept == CH_SPACE) || (cur_state.prev_kept == CH_NL) ||
		(cur_state.prev_kept == CH_LPAR) || (cur_state.prev_kept == CH_LSQ);
	assign kept      = (b == CH_NL) ? CH_SPACE : b;

	always_comb begin
		next_state = cur_state;
		keep       = 1'b0;
		if (cur_state.drop_next) begin
			next_state.drop_next = 1'b0;
		end else begin
			if (!commented && b == CH_QUOTE && cur_state.prev_kept != CH_BSLASH) begin
				next_state.in_quote = ~cur_state.in_quote;
			end
			if (next_state.in_quote) begin
				keep = 1'b1;
			end else begin
				if (!commented && b == CH_SLASH) begin
					if (nx == CH_SLASH) begin
						next_state.in_line_comment = 1'b1;
						next_state.drop_next       = 1'b1;
					end else if (nx == CH_STAR) begin
						next_state.in_block_comment = 1'b1;
						next_state.drop_next        = 1'b1;
					end
				end
				if (next_state.in_line_comment && b == CH_NL) begin
					next_state.in_line_comment = 1'b0;
				end else if (next_state.in_block_comment && b == CH_STAR && nx == CH_SLASH) begin
					next_state.in_block_comment = 1'b0;
					next_state.drop_next        = 1'b1;
				end else if (next_state.in_line_comment || next_state.in_block_comment) begin
					keep = 1'b0;
				end else if (b_blank && (prev_open || nx == CH_RPAR || nx == CH_RSQ)) begin
					keep = 1'b0;
				end else begin
					keep = 1'b1;
				end
			end
			if (keep) begin
				next_state.prev_kept = kept;
			end
		end
	end

endmodule

// File: design/csstrip_outq.sv
// Small result queue: up to two writes and one read per cycle.
`include "comment_and_space_stripper_macros.svh"
module csstrip_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_cnt,
	input  csstrip_pkg::strip_res_t push0,
	input  csstrip_pkg::strip_res_t push1,
	output logic                   room,
	output logic                   out_valid,
	input  logic                   out_ready,
	output csstrip_pkg::strip_res_t head
);
	import csstrip_pkg::*;

	strip_res_t            slot_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q;
	logic [OQ_PTR_W-1:0]   rd_ptr_q;
	logic [OQ_CNT_W-1:0]   count_q;
	logic                  pop;
	logic [OQ_PTR_W-1:0]   wr_ptr_p1;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid & out_ready;
	assign head      = slot_q[rd_ptr_q];
	// two free slots needed, ignoring a read in the same cycle
	assign room      = (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + OQ_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			slot_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			slot_q[wr_ptr_p1] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			end
			count_q <= count_q + OQ_CNT_W'(push_cnt) - OQ_CNT_W'(pop);
		end
	end

	`CSS_ASSERT(a_oq_bound, count_q <= OQ_CNT_W'(OQ_DEPTH), "result queue count out of range")
	`CSS_ASSERT(a_oq_room, (push_cnt == 2'd0) || room, "result written without room")
	`CSS_ASSERT(a_oq_ptrs, OQ_PTR_W'(wr_ptr_q - rd_ptr_q) == OQ_PTR_W'(count_q), "queue pointers disagree with count")

endmodule

// File: design/comment_and_space_stripper.sv
// Top level of the comment and space stripper: input stage, scanner and result queue.
//
// Usage notes:
// - Input channel (in_valid/in_ready, char_in, last_in) takes one source byte per request;
//   last_in marks the final byte of a text.
// - Output channel (out_valid/out_ready) gives char_out, has_char, end_of_text and
//   last_of_run per request. has_char low means an end marker with no byte.
// - One byte is held back until its follower arrives, so a byte's result appears only
//   after the next byte (or the final byte) has been taken.
// - Path: a taken request is registered in the input stage and judged there once the
//   queue has room; the results it completes are then written to the result queue.
// - Throughput: one byte per cycle while the queue has room. A final byte may give
//   two results; they leave by the single read port of the four-entry result queue.
// - The scanner runs only when the queue has two free slots; while the receiver
//   stalls the queue fills and in_ready drops, and nothing is lost.
// - Reset (arst_n low) empties the input stage and the queue and returns the flags to
//   their idle values (previous kept byte a space). After every final byte the flags
//   return to the same values, so the next byte starts a new text.
`include "comment_and_space_stripper_macros.svh"
module comment_and_space_stripper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       last_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_out,
	output logic       has_char,
	output logic       end_of_text,
	output logic       last_of_run
);
	import csstrip_pkg::*;

	// input stage
	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         last_s1;

	// scanner state
	logic [7:0]   held_byte_q;
	logic         held_valid_q;
	strip_state_t st_q;

	logic         room;
	logic         fire;
	strip_state_t st_j1;
	strip_state_t st_j2;
	strip_state_t st_mid;
	logic         keep_j1;
	logic         keep_j2;
	logic [7:0]   kept_j1;
	logic [7:0]   kept_j2;
	logic         keep1;
	logic         keep2;
	logic [1:0]   push_cnt;
	strip_res_t   push0;
	strip_res_t   push1;
	strip_res_t   head;
	logic         scan_idle;

	assign fire     = valid_s1 & room;
	assign in_ready = ~valid_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			last_s1 <= last_in;
		end
	end

	// held byte judged against the incoming one
	csstrip_judge u_judge_held (
		.cur_state  (st_q),
		.b          (held_byte_q),
		.nx         (char_s1),
		.next_state (st_j1),
		.keep       (keep_j1),
		.kept       (kept_j1)
	);

	assign keep1  = held_valid_q & keep_j1;
	assign st_mid = held_valid_q ? st_j1 : st_q;

	// final byte judged against a follower of zero
	csstrip_judge u_judge_last (
		.cur_state  (st_mid),
		.b          (char_s1),
		.nx         (CH_NUL),
		.next_state (st_j2),
		.keep       (keep_j2),
		.kept       (kept_j2)
	);

	assign keep2 = last_s1 & keep_j2;

	always_comb begin
		push_cnt = 2'd0;
		push0    = '{char_out: CH_NUL, has_char: 1'b0, end_of_text: last_s1,
			last_of_run: 1'b1};
		push1    = '{char_out: kept_j2, has_char: 1'b1, end_of_text: last_s1,
			last_of_run: 1'b1};
		if (fire) begin
			if (keep1 && keep2) begin
				push_cnt = 2'd2;
				push0    = '{char_out: kept_j1, has_char: 1'b1, end_of_text: 1'b0,
					last_of_run: 1'b0};
			end else if (keep1) begin
				push_cnt       = 2'd1;
				push0.char_out = kept_j1;
				push0.has_char = 1'b1;
			end else if (keep2) begin
				push_cnt       = 2'd1;
				push0.char_out = kept_j2;
				push0.has_char = 1'b1;
			end else if (last_s1) begin
				// nothing kept: end marker only
				push_cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			st_q         <= STATE_RESET;
		end else if (fire) begin
			if (last_s1) begin
				held_valid_q <= 1'b0;
				st_q         <= STATE_RESET;
			end else begin
				held_valid_q <= 1'b1;
				st_q         <= st_mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			held_byte_q <= char_s1;
		end
	end

	csstrip_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (push0),
		.push1     (push1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign char_out    = head.char_out;
	assign has_char    = head.has_char;
	assign end_of_text = head.end_of_text;
	assign last_of_run = head.last_of_run;

	// scanner back at its idle values
	assign scan_idle = !held_valid_q && (st_q == STATE_RESET);

	`CSS_ASSERT_NEXT(a_last_clears, fire && last_s1, scan_idle, "state not cleared after final byte")
	`CSS_ASSERT(a_mid_one, !(fire && !last_s1) || push_cnt <= 2'd1, "two results from a mid byte")
	`CSS_ASSERT(a_last_some, !(fire && last_s1) || push_cnt != 2'd0, "final byte gave no result")

endmodule

// File: dv/comment_and_space_stripper_checker.sv
// Scoreboard for the comment and space stripper: predicts each request's results and compares.
module comment_and_space_stripper_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       last_in,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] char_out,
	input  logic       has_char,
	input  logic       end_of_text,
	input  logic       last_of_run,
	output int         fail_count,
	output int         pending
);
	import csstrip_pkg::*;

	// predicted scanner state
	logic [7:0] hold_byte;
	bit         hold_ok;
	logic [7:0] last_kept;
	bit         quoting;
	bit         line_cmt;
	bit         block_cmt;
	bit         skip_next;

	strip_res_t expected_out[$];

	task clear_scan();
		hold_byte = CH_NUL;
		hold_ok   = 1'b0;
		last_kept = CH_SPACE;
		quoting   = 1'b0;
		line_cmt  = 1'b0;
		block_cmt = 1'b0;
		skip_next = 1'b0;
	endtask

	function bit is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_NL;
	endfunction

	// decide whether byte b survives, given the byte that follows it
	function bit judge_byte(input logic [7:0] b_in, input logic [7:0] nx,
			output logic [7:0] kept);
		logic [7:0] b;
		bit         commented;
		b    = b_in;
		kept = CH_NUL;
		if (skip_next) begin
			skip_next = 1'b0;
			return 1'b0;
		end
		commented = line_cmt || block_cmt;
		if (!commented && b == CH_QUOTE && last_kept != CH_BSLASH)
			quoting = !quoting;
		if (!quoting) begin
			if (!commented && b == CH_SLASH) begin
				if (nx == CH_SLASH) begin
					line_cmt  = 1'b1;
					skip_next = 1'b1;
				end else if (nx == CH_STAR) begin
					block_cmt = 1'b1;
					skip_next = 1'b1;
				end
			end
			if (line_cmt && b == CH_NL) begin
				line_cmt = 1'b0;
				return 1'b0;
			end
			if (block_cmt && b == CH_STAR && nx == CH_SLASH) begin
				block_cmt = 1'b0;
				skip_next = 1'b1;
				return 1'b0;
			end
			if (line_cmt || block_cmt)
				return 1'b0;
			if (is_blank(b) && (is_blank(last_kept) || last_kept == CH_LPAR ||
					last_kept == CH_LSQ || nx == CH_RPAR || nx == CH_RSQ))
				return 1'b0;
		end
		if (b == CH_NL)
			b = CH_SPACE;
		last_kept = b;
		kept      = b;
		return 1'b1;
	endfunction

	task predict_request(input logic [7:0] b, input logic fin);
		logic [7:0] got0;
		logic [7:0] got1;
		logic [7:0] k;
		int         n;
		strip_res_t r;
		n = 0;
		if (hold_ok) begin
			if (judge_byte(hold_byte, b, k)) begin
				got0 = k;
				n    = 1;
			end
		end
		hold_byte = b;
		hold_ok   = 1'b1;
		if (fin) begin
			if (judge_byte(b, CH_NUL, k)) begin
				if (n == 0)
					got0 = k;
				else
					got1 = k;
				n = n + 1;
			end
		end
		for (int i = 0; i < n; i++) begin
			r.char_out    = (i == 0) ? got0 : got1;
			r.has_char    = 1'b1;
			r.end_of_text = fin && (i == n - 1);
			r.last_of_run = (i == n - 1);
			expected_out.insert(expected_out.size(), r);
		end
		if (fin && n == 0) begin
			r = '{char_out: CH_NUL, has_char: 1'b0, end_of_text: 1'b1, last_of_run: 1'b1};
			expected_out.insert(expected_out.size(), r);
		end
		if (fin)
			clear_scan();
	endtask

	task report_mismatch(input string msg);
		if (fail_count < 40)
			$display("mismatch: %s", msg);
		fail_count = fail_count + 1;
	endtask

	task check_result();
		strip_res_t want;
		if (expected_out.size() == 0) begin
			report_mismatch($sformatf("unexpected result char %02h has %0d",
				char_out, has_char));
		end else begin
			want = expected_out[0];
			expected_out.delete(0);
			if (char_out !== want.char_out)
				report_mismatch($sformatf("char_out %02h, want %02h", char_out, want.char_out));
			if (has_char !== want.has_char)
				report_mismatch($sformatf("has_char %0d, want %0d", has_char, want.has_char));
			if (end_of_text !== want.end_of_text)
				report_mismatch($sformatf("end_of_text %0d, want %0d",
					end_of_text, want.end_of_text));
			if (last_of_run !== want.last_of_run)
				report_mismatch($sformatf("last_of_run %0d, want %0d",
					last_of_run, want.last_of_run));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_out.delete();
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_request(char_in, last_in);
			if (out_valid && out_ready)
				check_result();
			pending <= expected_out.size();
		end
	end

endmodule

// File: dv/tb_comment_and_space_stripper.sv
// Testbench top for the comment and space stripper: stimulus, back-pressure and verdict.
module tb_comment_and_space_stripper;
	import csstrip_pkg::*;

	// Allowance for a run with every gap and stall at its longest, several times over.
	localparam int CYCLE_LIMIT  = 200000;
	// Bytes of random text to send after the directed texts.
	localparam int RANDOM_BYTES = 500;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] char_in     = 8'h00;
	logic       last_in     = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] char_out;
	logic       has_char;
	logic       end_of_text;
	logic       last_of_run;

	int         fail_count;
	int         pending;
	int         cycles      = 0;

	// When set, neither side idles: back-to-back requests at full rate.
	bit         steady      = 1'b0;

	// Text under construction for the random part.
	logic [7:0] text_q[$];

	comment_and_space_stripper i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_in     (char_in),
		.last_in     (last_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_out    (char_out),
		.has_char    (has_char),
		.end_of_text (end_of_text),
		.last_of_run (last_of_run)
	);

	comment_and_space_stripper_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_in     (char_in),
		.last_in     (last_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_out    (char_out),
		.has_char    (has_char),
		.end_of_text (end_of_text),
		.last_of_run (last_of_run),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** comment_and_space_stripper: FAILED **");
			$finish;
		end
	end

	// Idle length: mostly none, else a random pause, now and then from a longer range.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// Receiver back-pressure: ready for a while, then a stall of random length.
	// Every assignment is followed by a clock edge before the next, so one update per step.
	initial begin
		wait (arst_n);
		forever begin
			int on_len;
			int off_len;
			on_len  = $urandom_range(1, 8);
			off_len = gap_len();
			out_ready <= 1'b1;
			repeat (on_len) @(posedge clk);
			if (off_len > 0) begin
				out_ready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	// Offer one byte and hold it until the request is taken. With no gap the next
	// request follows straight on, so valid is never lowered and raised in one step.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in  <= b;
		last_in  <= fin;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], i == s.len() - 1);
	endtask

	// Byte from the characters the scanner cares about, with some plain noise.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 13))
			0:       return CH_SLASH;
			1:       return CH_STAR;
			2:       return CH_SPACE;
			3:       return CH_NL;
			4:       return CH_LPAR;
			5:       return CH_RPAR;
			6:       return CH_LSQ;
			7:       return CH_RSQ;
			8:       return CH_QUOTE;
			9:       return CH_BSLASH;
			10:      return 8'($urandom_range(0, 255));
			default: return 8'h61 + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// Append one byte to the text under construction.
	task automatic add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endtask

	task automatic add_body(input int max_len);
		int n;
		n = $urandom_range(0, max_len);
		for (int i = 0; i < n; i++)
			add_byte(pick_byte());
	endtask

	// Build a text mostly from well-formed pieces (comments, strings, bracket and
	// blank runs) with random content, salted with noise and unterminated pieces.
	task automatic build_text();
		int target;
		target = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
		text_q.delete();
		while (text_q.size() < target) begin
			case ($urandom_range(0, 9))
				0: add_byte(8'($urandom_range(0, 255)));
				1: begin
					add_byte(CH_SLASH);
					add_byte(CH_SLASH);
					add_body(4);
					if ($urandom_range(0, 7) != 0)
						add_byte(CH_NL);
				end
				2: begin
					add_byte(CH_SLASH);
					add_byte(CH_STAR);
					add_body(4);
					if ($urandom_range(0, 7) != 0) begin
						add_byte(CH_STAR);
						add_byte(CH_SLASH);
					end
				end
				3: begin
					add_byte(CH_QUOTE);
					add_body(4);
					if ($urandom_range(0, 7) != 0)
						add_byte(CH_QUOTE);
				end
				4: begin
					repeat ($urandom_range(1, 3))
						add_byte($urandom_range(0, 1) ? CH_SPACE : CH_NL);
				end
				5: add_byte(pick_byte());
				6: begin
					add_byte($urandom_range(0, 1) ? CH_LPAR : CH_LSQ);
					if ($urandom_range(0, 1))
						add_byte(CH_SPACE);
				end
				7: begin
					if ($urandom_range(0, 1))
						add_byte(CH_NL);
					add_byte($urandom_range(0, 1) ? CH_RPAR : CH_RSQ);
				end
				default: add_byte(8'h61 + 8'($urandom_range(0, 25)));
			endcase
		end
	endtask

	initial begin
		int sent;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed texts.
		send_text("(a )");          // blank before a closing bracket dropped
		send_text("/*x*/y");        // byte after a block comment end is kept
		send_text("a/");            // lone slash as final byte: two results
		send_text("//z\n");         // everything removed: end marker only
		send_text("\"\\\"");        // escaped quote, string left open at the end
		send_byte(CH_NUL, 1'b0);    // zero byte inside text, then 0xFF as final
		send_byte(8'hFF, 1'b1);
		send_text(" ");             // lone blank after reset state: end marker
		send_text("a\nb");          // kept newline goes out as a space

		// Random texts; every fifth or so runs with no idling on either side.
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			build_text();
			steady = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < text_q.size(); i++)
				send_byte(text_q[i], i == text_q.size() - 1);
			sent = sent + text_q.size();
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// The checker's count is registered and so lags, hence the step before looking at it.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("** comment_and_space_stripper: PASSED **");
		else
			$display("** comment_and_space_stripper: FAILED **");
		$finish;
	end

endmodule
